### src/telescope_hit_event_builder_assert.svh
// Assertion macros for the telescope hit event builder.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef TELESCOPE_HIT_EVENT_BUILDER_ASSERT_SVH
`define TELESCOPE_HIT_EVENT_BUILDER_ASSERT_SVH
`ifndef SYNTH
// Checked property, ignored while reset is high.
`define THEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define THEB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define THEB_ASSERT(lbl, prop, msg)
`define THEB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### src/theb_pkg.sv
// Shared types and constants of the telescope hit event builder.
// No dependencies; imported by the interfaces and every module.
package theb_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_X     = 2'd0;
  localparam logic [1:0] CMD_Y     = 2'd1;
  localparam logic [1:0] CMD_THICK = 2'd2;
  localparam logic [1:0] CMD_EOE   = 2'd3;

  // Record kind codes.
  localparam logic [2:0] KIND_X     = 3'd0;
  localparam logic [2:0] KIND_Y     = 3'd1;
  localparam logic [2:0] KIND_THICK = 3'd2;
  localparam logic [2:0] KIND_TOTAL = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_THR      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_THR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_THR_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_THR_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_THR_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THICK_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DE_STRIPS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TELESCOPE  = 3'd7;

  // Strip search floor, -500.0 in Q16.16.
  localparam logic signed [31:0] FLOOR_Q16 = -32'sd32768000;

  // Thick detector index wide enough for the largest supported count (8).
  localparam int THICK_IDX_W = 3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_EMIT_X,
    ST_EMIT_Y,
    ST_EMIT_THICK,
    ST_EMIT_TOTAL,
    ST_EMIT_ERR
  } ctrl_state_t;

  // Which record the datapath assembles.
  typedef enum logic [2:0] {
    SEL_X,
    SEL_Y,
    SEL_THICK,
    SEL_TOTAL,
    SEL_ERR
  } rec_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                   load_hit;
    logic                   clear;
    logic                   load_out;
    rec_sel_t               sel;
    logic [THICK_IDX_W-1:0] thick_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       any_hit;
    logic       overflow;
    logic [3:0] n_use;
  } dp_stat_t;

endpackage

### src/theb_ifs.sv
// Channel interfaces of the telescope hit event builder: hits, records, config.
// Depends on theb_pkg.
interface theb_hit_if import theb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         detector_id;
  logic signed [31:0] hit_energy;
  logic signed [31:0] hit_time;

  modport source (output valid, cmd, detector_id, hit_energy, hit_time, input ready);
  modport sink (input valid, cmd, detector_id, hit_energy, hit_time, output ready);
endinterface

interface theb_rec_if import theb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         index;
  logic               hit_valid;
  logic signed [31:0] energy;
  logic signed [31:0] timing;
  logic signed [31:0] de_energy;
  logic signed [35:0] total_energy;
  logic               last;

  modport source (output valid, kind, index, hit_valid, energy, timing, de_energy,
                  total_energy, last, input ready);
  modport sink (input valid, kind, index, hit_valid, energy, timing, de_energy,
                total_energy, last, output ready);
endinterface

interface theb_cfg_if import theb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/theb_datapath.sv
// Datapath: configuration registers, per-event hit state, record assembly and
// the output record register. Depends on theb_pkg and theb_cfg_if.
module theb_datapath import theb_pkg::*; #(
  parameter int NUM_THICK = 3
) (
  input  logic               clk,
  input  logic               rst,
  theb_cfg_if.sink           cfg,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_detector_id,
  input  logic signed [31:0] in_hit_energy,
  input  logic signed [31:0] in_hit_time,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [2:0]         kind,
  output logic [7:0]         index,
  output logic               hit_valid,
  output logic signed [31:0] energy,
  output logic signed [31:0] timing,
  output logic signed [31:0] de_energy,
  output logic signed [35:0] total_energy,
  output logic               last
);

  localparam int TW = (NUM_THICK > 1) ? $clog2(NUM_THICK) : 1;
  localparam logic [3:0] NUM_USE_MAX = 4'(NUM_THICK);

  // Configuration registers.
  logic signed [31:0] x_thr;
  logic signed [31:0] y_thr;
  logic signed [31:0] thick_thr_a;
  logic signed [31:0] thick_thr_b;
  logic signed [31:0] thick_thr_c;
  logic [3:0]         thick_count;
  logic               de_from_strips;
  logic [7:0]         telescope_number;

  // Per-event state.
  logic signed [31:0] x_best_energy;
  logic [7:0]         x_best_id;
  logic signed [31:0] x_best_time;
  logic               x_seen;
  logic signed [31:0] y_best_energy;
  logic [7:0]         y_best_id;
  logic signed [31:0] y_best_time;
  logic               y_seen;
  logic signed [31:0] thick_energy [NUM_THICK];
  logic signed [31:0] thick_time [NUM_THICK];
  logic [NUM_THICK-1:0] thick_valid;
  logic signed [34:0] thick_sum;
  logic [7:0]         thick_hits;
  logic               any_hit;

  logic [3:0]         n_use;
  logic signed [31:0] hit_thr;
  logic               thick_take;
  logic               thick_count_ok;
  logic [TW-1:0]      hit_tid;
  logic [TW-1:0]      rd_tid;

  logic               xv;
  logic               yv;
  logic               anyv;
  logic signed [31:0] de_val;
  logic signed [31:0] sum_sat;
  logic signed [35:0] total_val;

  logic [2:0]         kind_next;
  logic [7:0]         index_next;
  logic               hit_valid_next;
  logic signed [31:0] energy_next;
  logic signed [31:0] timing_next;
  logic signed [31:0] de_energy_next;
  logic signed [35:0] total_energy_next;
  logic               last_next;

  // Configuration writes are always accepted.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_thr            <= '0;
      y_thr            <= '0;
      thick_thr_a      <= '0;
      thick_thr_b      <= '0;
      thick_thr_c      <= '0;
      thick_count      <= 4'd3;
      de_from_strips   <= 1'b1;
      telescope_number <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_X_THR:       x_thr            <= cfg.data;
        REG_Y_THR:       y_thr            <= cfg.data;
        REG_THICK_THR_A: thick_thr_a      <= cfg.data;
        REG_THICK_THR_B: thick_thr_b      <= cfg.data;
        REG_THICK_THR_C: thick_thr_c      <= cfg.data;
        REG_THICK_COUNT: thick_count      <= cfg.data[3:0];
        REG_DE_STRIPS:   de_from_strips   <= cfg.data[0];
        REG_TELESCOPE:   telescope_number <= cfg.data[7:0];
      endcase
    end
  end

  // Detectors in use, clamped to the instantiated count.
  assign n_use = (thick_count > NUM_USE_MAX) ? NUM_USE_MAX : thick_count;

  // Threshold of the detector named by the incoming hit; higher ids use zero.
  always_comb begin
    unique case (in_detector_id)
      8'd0:    hit_thr = thick_thr_a;
      8'd1:    hit_thr = thick_thr_b;
      8'd2:    hit_thr = thick_thr_c;
      default: hit_thr = '0;
    endcase
  end

  assign hit_tid        = in_detector_id[TW-1:0];
  assign thick_count_ok = (thick_hits != 8'hFF);
  assign thick_take     = (in_detector_id < {4'b0, n_use}) && (in_hit_energy > hit_thr);

  // Event state update: strip maximum search, thick hit count and sum.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      x_best_energy <= FLOOR_Q16;
      x_best_id     <= '0;
      x_best_time   <= '0;
      x_seen        <= 1'b0;
      y_best_energy <= FLOOR_Q16;
      y_best_id     <= '0;
      y_best_time   <= '0;
      y_seen        <= 1'b0;
      thick_valid   <= '0;
      thick_sum     <= '0;
      thick_hits    <= '0;
      any_hit       <= 1'b0;
    end else if (cmd.load_hit) begin
      any_hit <= 1'b1;
      unique case (in_cmd)
        CMD_X: begin
          if (x_best_energy < in_hit_energy) begin
            x_best_energy <= in_hit_energy;
            x_best_id     <= in_detector_id;
            x_best_time   <= in_hit_time;
            x_seen        <= 1'b1;
          end
        end
        CMD_Y: begin
          if (y_best_energy < in_hit_energy) begin
            y_best_energy <= in_hit_energy;
            y_best_id     <= in_detector_id;
            y_best_time   <= in_hit_time;
            y_seen        <= 1'b1;
          end
        end
        CMD_THICK: begin
          if (thick_count_ok) begin
            thick_hits <= thick_hits + 8'd1;
            if (thick_take) begin
              thick_valid[hit_tid] <= 1'b1;
              thick_sum <= thick_sum + {{3{in_hit_energy[31]}}, in_hit_energy};
            end
          end
        end
        CMD_EOE: begin
        end
      endcase
    end
  end

  // Stored thick hit values; only read where the valid bit is set.
  always_ff @(posedge clk) begin
    if (cmd.load_hit && in_cmd == CMD_THICK && thick_count_ok && thick_take) begin
      thick_energy[hit_tid] <= in_hit_energy;
      thick_time[hit_tid]   <= in_hit_time;
    end
  end

  assign stat.any_hit  = any_hit;
  assign stat.overflow = (thick_hits > {4'b0, n_use});
  assign stat.n_use    = n_use;

  // Report decisions and totals.
  assign xv = x_seen && (x_best_energy > x_thr);
  assign yv = y_seen && (y_best_energy > y_thr);

  always_comb begin
    anyv = xv || yv;
    for (int i = 0; i < NUM_THICK; i++) begin
      if (4'(i) < n_use) begin
        anyv = anyv || thick_valid[i];
      end
    end
  end

  assign de_val = (de_from_strips && xv) ? x_best_energy : '0;

  // The sum fits 32 bits when its top four bits agree.
  always_comb begin
    if ((thick_sum[34:31] == 4'b0000) || (thick_sum[34:31] == 4'b1111)) begin
      sum_sat = thick_sum[31:0];
    end else if (thick_sum[34]) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = 32'sh7FFF_FFFF;
    end
  end

  // At most eight thick hits are summed here, so 36 bits cannot overflow.
  assign total_val = {{4{de_val[31]}}, de_val} + {thick_sum[34], thick_sum};

  assign rd_tid = cmd.thick_idx[TW-1:0];

  // Assemble the selected record.
  always_comb begin
    kind_next         = KIND_X;
    index_next        = '0;
    hit_valid_next    = 1'b0;
    energy_next       = '0;
    timing_next       = '0;
    de_energy_next    = '0;
    total_energy_next = '0;
    last_next         = 1'b0;
    unique case (cmd.sel)
      SEL_X: begin
        kind_next      = KIND_X;
        hit_valid_next = xv;
        if (xv) begin
          index_next  = x_best_id;
          energy_next = x_best_energy;
          timing_next = x_best_time;
        end
      end
      SEL_Y: begin
        kind_next      = KIND_Y;
        hit_valid_next = yv;
        if (yv) begin
          index_next  = y_best_id;
          energy_next = y_best_energy;
          timing_next = y_best_time;
        end
      end
      SEL_THICK: begin
        kind_next      = KIND_THICK;
        index_next     = {{(8-THICK_IDX_W){1'b0}}, cmd.thick_idx};
        hit_valid_next = thick_valid[rd_tid];
        if (thick_valid[rd_tid]) begin
          energy_next = thick_energy[rd_tid];
          timing_next = thick_time[rd_tid];
        end
      end
      SEL_TOTAL: begin
        kind_next         = KIND_TOTAL;
        index_next        = telescope_number;
        hit_valid_next    = anyv;
        energy_next       = sum_sat;
        de_energy_next    = de_val;
        total_energy_next = total_val;
        last_next         = 1'b1;
      end
      SEL_ERR: begin
        kind_next  = KIND_ERR;
        index_next = thick_hits;
        last_next  = 1'b1;
      end
    endcase
  end

  // Output record register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind         <= kind_next;
      index        <= index_next;
      hit_valid    <= hit_valid_next;
      energy       <= energy_next;
      timing       <= timing_next;
      de_energy    <= de_energy_next;
      total_energy <= total_energy_next;
      last         <= last_next;
    end
  end

endmodule

### src/theb_ctrl.sv
// Controller: collects hits and sequences the record requests of one event.
// Depends on theb_pkg.
module theb_ctrl import theb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  ctrl_state_t            state;
  ctrl_state_t            state_next;
  logic [THICK_IDX_W-1:0] thick_idx;
  logic                   slot_free;
  logic                   eoe_accept;
  logic                   thick_done;

  assign slot_free  = !out_valid || out_ready;
  assign eoe_accept = (state == ST_COLLECT) && in_valid && (in_cmd == CMD_EOE);
  assign thick_done = ({1'b0, thick_idx} + 4'd1) == stat.n_use;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (eoe_accept && stat.any_hit) begin
          state_next = stat.overflow ? ST_EMIT_ERR : ST_EMIT_X;
        end
      end
      ST_EMIT_X: begin
        if (slot_free) state_next = ST_EMIT_Y;
      end
      ST_EMIT_Y: begin
        if (slot_free) state_next = (stat.n_use == 4'd0) ? ST_EMIT_TOTAL : ST_EMIT_THICK;
      end
      ST_EMIT_THICK: begin
        if (slot_free && thick_done) state_next = ST_EMIT_TOTAL;
      end
      ST_EMIT_TOTAL, ST_EMIT_ERR: begin
        if (slot_free) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    in_ready       = (state == ST_COLLECT);
    cmd.load_hit   = (state == ST_COLLECT) && in_valid && (in_cmd != CMD_EOE);
    cmd.clear      = (eoe_accept && !stat.any_hit) ||
                     (((state == ST_EMIT_TOTAL) || (state == ST_EMIT_ERR)) && slot_free);
    cmd.load_out   = (state != ST_COLLECT) && slot_free;
    cmd.thick_idx  = thick_idx;
    unique case (state)
      ST_EMIT_Y:     cmd.sel = SEL_Y;
      ST_EMIT_THICK: cmd.sel = SEL_THICK;
      ST_EMIT_TOTAL: cmd.sel = SEL_TOTAL;
      ST_EMIT_ERR:   cmd.sel = SEL_ERR;
      default:       cmd.sel = SEL_X;
    endcase
  end

  // State, thick record counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      thick_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT_Y) begin
        thick_idx <= '0;
      end else if (state == ST_EMIT_THICK && slot_free) begin
        thick_idx <= thick_idx + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/telescope_hit_event_builder.sv
// Hits are taken one per cycle and folded into the event state at the accepting edge.
// An end-of-event request after a hit moves the controller to an emit state that loads
// the first record into the output register; records then leave one per cycle while the
// sink is ready: 3 + n records (n = thick detectors in use), or one error record. No hit
// is taken during that emission. Reset (synchronous, active high) loads register defaults
// and clears the event state at once; there is no clearing pass.
`include "telescope_hit_event_builder_assert.svh"

module telescope_hit_event_builder import theb_pkg::*; #(
  parameter int NUM_THICK = 3
) (
  input logic      clk,
  input logic      rst,
  theb_hit_if.sink hit,
  theb_rec_if.source rec,
  theb_cfg_if.sink cfg
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing of hits and records.
  theb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hit.valid),
    .in_cmd    (hit.cmd),
    .in_ready  (hit.ready),
    .out_ready (rec.ready),
    .out_valid (rec.valid),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Event state, configuration and record formation.
  theb_datapath #(
    .NUM_THICK (NUM_THICK)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_cmd         (hit.cmd),
    .in_detector_id (hit.detector_id),
    .in_hit_energy  (hit.hit_energy),
    .in_hit_time    (hit.hit_time),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .kind           (rec.kind),
    .index          (rec.index),
    .hit_valid      (rec.hit_valid),
    .energy         (rec.energy),
    .timing         (rec.timing),
    .de_energy      (rec.de_energy),
    .total_energy   (rec.total_energy),
    .last           (rec.last)
  );

  // Checks on controller and datapath cooperation.
  `THEB_ASSERT(a_no_emit_while_collect, hit.ready |-> !dp_cmd.load_out, "record loaded while taking hits")
  `THEB_ASSERT(a_clear_empties_event, dp_cmd.clear |=> !dp_stat.any_hit, "event state not cleared")
  `THEB_ASSERT(a_load_shows_record, dp_cmd.load_out |=> rec.valid, "loaded record not presented")
  `THEB_ASSERT_RST(a_reset_no_record, rst |=> !rec.valid, "record valid after reset")

endmodule
